// ----- rtl/mcme_pkg.sv -----
// ============================================================================
// Matrix column multiply engine package
// Shared widths, register codes, operation codes and the request and status
// structures passed between the front end, the queue and the back end.
// ============================================================================
package mcme_pkg;

   // Payload field widths.
   localparam int unsigned ROW_W      = 4;
   localparam int unsigned COL_W      = 10;
   localparam int unsigned VALUE_W    = 16;
   localparam int unsigned PROD_W     = 32;
   localparam int unsigned SUM_W      = 36;

   // Configuration port and register widths.
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 11;
   localparam int unsigned DIM_CFG_W   = 5;
   localparam int unsigned COLS_CFG_W  = 11;
   localparam int unsigned MAX_COLS    = 1024;

   localparam logic [DIM_CFG_W-1:0]  ROW_COUNT_RESET   = 5'd16;
   localparam logic [DIM_CFG_W-1:0]  INNER_COUNT_RESET = 5'd16;
   localparam logic [COLS_CFG_W-1:0] COL_COUNT_RESET   = 11'd16;

   // Request queue between front and back.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = 2;
   localparam int unsigned QUEUE_CNT_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROW_COUNT   = 2'd0,
      CSR_INNER_COUNT = 2'd1,
      CSR_COL_COUNT   = 2'd2
   } mcme_csr_type;

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_STREAM = 1'b1
   } mcme_op_type;

   // One classified request as it sits in the queue.
   typedef struct packed {
      mcme_op_type               op;
      logic [ROW_W-1:0]          row_index;
      logic [COL_W-1:0]          col_index;
      logic signed [VALUE_W-1:0] value;
      logic                      first_k;
      logic                      last_k;
      logic                      last_col;
   } mcme_item_type;

   typedef struct packed {
      logic valid;
      logic full;
   } mcme_queue_status_type;

   typedef struct packed {
      logic pop;
      logic busy;
      logic drained;
   } mcme_back_status_type;

endpackage

// ----- rtl/mcme_front.sv -----
// ============================================================================
// Matrix column multiply engine front end
// Holds the configuration registers, accepts requests and classifies them:
// out-of-range loads and inner indexes are dropped, the rest are queued.
// ============================================================================
module mcme_front #(
   parameter int unsigned MAX_DIM = 16,
   parameter int unsigned DIM_W   = $clog2(MAX_DIM + 1)
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [mcme_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [mcme_pkg::CSR_DATA_W-1:0]         csr_wdata,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_mode,
   input  logic [mcme_pkg::ROW_W-1:0]              req_row_index,
   input  logic [mcme_pkg::COL_W-1:0]              req_col_index,
   input  logic signed [mcme_pkg::VALUE_W-1:0]     req_value,
   input  mcme_pkg::mcme_queue_status_type         q_status,
   output logic                                    q_push,
   output mcme_pkg::mcme_item_type                 q_item,
   output logic [DIM_W-1:0]                        rows_eff
);

   logic [mcme_pkg::DIM_CFG_W-1:0]  row_count_ff, row_count_in;
   logic [mcme_pkg::DIM_CFG_W-1:0]  inner_count_ff, inner_count_in;
   logic [mcme_pkg::COLS_CFG_W-1:0] col_count_ff, col_count_in;
   logic [DIM_W-1:0]                inner_eff;
   logic [mcme_pkg::COLS_CFG_W-1:0] cols_eff;
   logic                            load_ok;
   logic                            stream_ok;
   logic                            keep;

   assign csr_ready = 1'b1;

   always_comb begin
      row_count_in   = row_count_ff;
      inner_count_in = inner_count_ff;
      col_count_in   = col_count_ff;
      if (csr_valid) begin
         case (csr_index)
            mcme_pkg::CSR_ROW_COUNT: begin
               row_count_in = csr_wdata[mcme_pkg::DIM_CFG_W-1:0];
            end
            mcme_pkg::CSR_INNER_COUNT: begin
               inner_count_in = csr_wdata[mcme_pkg::DIM_CFG_W-1:0];
            end
            mcme_pkg::CSR_COL_COUNT: begin
               col_count_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff   <= mcme_pkg::ROW_COUNT_RESET;
         inner_count_ff <= mcme_pkg::INNER_COUNT_RESET;
         col_count_ff   <= mcme_pkg::COL_COUNT_RESET;
      end else begin
         row_count_ff   <= row_count_in;
         inner_count_ff <= inner_count_in;
         col_count_ff   <= col_count_in;
      end
   end

   // Out-of-range register values are saturated into the legal range.
   always_comb begin
      if (row_count_ff == '0) begin
         rows_eff = DIM_W'(1);
      end else if (32'(row_count_ff) > 32'(MAX_DIM)) begin
         rows_eff = DIM_W'(MAX_DIM);
      end else begin
         rows_eff = DIM_W'(row_count_ff);
      end

      if (inner_count_ff == '0) begin
         inner_eff = DIM_W'(1);
      end else if (32'(inner_count_ff) > 32'(MAX_DIM)) begin
         inner_eff = DIM_W'(MAX_DIM);
      end else begin
         inner_eff = DIM_W'(inner_count_ff);
      end

      if (col_count_ff == '0) begin
         cols_eff = mcme_pkg::COLS_CFG_W'(1);
      end else if (32'(col_count_ff) > 32'(mcme_pkg::MAX_COLS)) begin
         cols_eff = mcme_pkg::COLS_CFG_W'(mcme_pkg::MAX_COLS);
      end else begin
         cols_eff = col_count_ff;
      end
   end

   assign load_ok   = (32'(req_row_index) < 32'(MAX_DIM)) &&
                      (32'(req_col_index) < 32'(MAX_DIM));
   assign stream_ok = 32'(req_row_index) < 32'(inner_eff);
   assign keep      = (req_mode == mcme_pkg::OP_LOAD) ? load_ok : stream_ok;

   assign req_stall = q_status.full;
   assign q_push    = req_valid && !q_status.full && keep;

   always_comb begin
      q_item.op        = mcme_pkg::mcme_op_type'(req_mode);
      q_item.row_index = req_row_index;
      q_item.col_index = req_col_index;
      q_item.value     = req_value;
      q_item.first_k   = (req_row_index == '0);
      q_item.last_k    = (32'(req_row_index) == (32'(inner_eff) - 32'd1));
      q_item.last_col  = ({1'b0, req_col_index} == (cols_eff - mcme_pkg::COLS_CFG_W'(1)));
   end

endmodule

// ----- rtl/mcme_queue.sv -----
// ============================================================================
// Matrix column multiply engine request queue
// A short first-in first-out queue of classified requests that decouples the
// front end from the back end.
// ============================================================================
module mcme_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  mcme_pkg::mcme_item_type         push_item,
   input  logic                            pop,
   output mcme_pkg::mcme_item_type         head_item,
   output mcme_pkg::mcme_queue_status_type status
);

   mcme_pkg::mcme_item_type                entries [mcme_pkg::QUEUE_DEPTH];
   logic [mcme_pkg::QUEUE_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [mcme_pkg::QUEUE_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [mcme_pkg::QUEUE_CNT_W-1:0]       count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item    = entries[rd_ptr_ff];
   assign status.valid = (count_ff != '0);
   assign status.full  = (count_ff == mcme_pkg::QUEUE_CNT_W'(mcme_pkg::QUEUE_DEPTH));

endmodule

// ----- rtl/mcme_back.sv -----
// ============================================================================
// Matrix column multiply engine back end
// Executes queued requests: loads write the left matrix store, streamed
// elements walk the active rows through a read, multiply, accumulate pipe.
// ============================================================================
module mcme_back #(
   parameter int unsigned MAX_DIM = 16,
   parameter int unsigned DIM_W   = $clog2(MAX_DIM + 1)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mcme_pkg::mcme_queue_status_type      q_status,
   input  mcme_pkg::mcme_item_type              q_item,
   output logic                                 q_pop,
   input  logic [DIM_W-1:0]                     rows_eff,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [mcme_pkg::ROW_W-1:0]           rsp_out_row,
   output logic [mcme_pkg::COL_W-1:0]           rsp_out_col,
   output logic signed [mcme_pkg::SUM_W-1:0]    rsp_sum_value,
   output logic                                 rsp_last_of_column,
   output logic                                 rsp_last_of_matrix,
   output mcme_pkg::mcme_back_status_type       status
);

   localparam int unsigned IDX_W       = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int unsigned STORE_DEPTH = MAX_DIM * MAX_DIM;
   localparam int unsigned ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   logic signed [mcme_pkg::VALUE_W-1:0] store_mem [STORE_DEPTH];
   logic [mcme_pkg::SUM_W-1:0]          acc_mem [MAX_DIM];

   logic [MAX_DIM-1:0]                  acc_valid_ff, acc_valid_in;
   logic                                busy_ff, busy_in;
   logic [IDX_W-1:0]                    row_ff, row_in;
   logic [ADDR_W-1:0]                   addr_ff, addr_in;
   logic                                s1_valid_ff, s1_valid_in;
   logic                                s2_valid_ff, s2_valid_in;
   logic                                rsp_valid_ff, rsp_valid_in;

   logic signed [mcme_pkg::VALUE_W-1:0] val_ff;
   logic [mcme_pkg::COL_W-1:0]          col_ff;
   logic                                emit_ff;
   logic                                eom_ff;

   logic signed [mcme_pkg::VALUE_W-1:0] a_rd_ff;
   logic [mcme_pkg::SUM_W-1:0]          acc_rd_ff;
   logic                                acc_ok_ff;
   logic [IDX_W-1:0]                    s1_row_ff;
   logic                                s1_lastrow_ff;

   logic signed [mcme_pkg::PROD_W-1:0]  prod_ff;
   logic [mcme_pkg::SUM_W-1:0]          base_ff;
   logic [IDX_W-1:0]                    s2_row_ff;
   logic                                s2_lastrow_ff;

   logic [mcme_pkg::ROW_W-1:0]          rsp_row_ff;
   logic [mcme_pkg::COL_W-1:0]          rsp_col_ff;
   logic signed [mcme_pkg::SUM_W-1:0]   rsp_sum_ff;
   logic                                rsp_lastcol_ff;
   logic                                rsp_eom_ff;

   logic                                drained;
   logic                                hold;
   logic                                adv;
   logic                                row_last;
   logic                                stream_start;
   logic                                load_write;
   logic [ADDR_W-1:0]                   load_addr;
   logic [mcme_pkg::SUM_W-1:0]          acc_sum;

   assign drained  = !busy_ff && !s1_valid_ff && !s2_valid_ff;
   // The pipe freezes only when a result must leave and the output is full.
   assign hold     = s2_valid_ff && emit_ff && rsp_valid_ff && rsp_stall;
   assign adv      = !hold;
   assign row_last = (DIM_W'(row_ff) == (rows_eff - DIM_W'(1)));

   // A load only needs the store port free; a streamed element also needs
   // every accumulator write of the previous element retired.
   assign q_pop = q_status.valid &&
                  ((q_item.op == mcme_pkg::OP_LOAD) ? !busy_ff : drained);
   assign stream_start = q_pop && (q_item.op == mcme_pkg::OP_STREAM);
   assign load_write   = q_pop && (q_item.op == mcme_pkg::OP_LOAD);
   assign load_addr    = ADDR_W'(32'(q_item.row_index) * MAX_DIM + 32'(q_item.col_index));

   assign acc_sum = base_ff + mcme_pkg::SUM_W'(prod_ff);

   always_comb begin
      busy_in      = busy_ff;
      row_in       = row_ff;
      addr_in      = addr_ff;
      acc_valid_in = acc_valid_ff;
      if (stream_start) begin
         busy_in = 1'b1;
         row_in  = '0;
         addr_in = ADDR_W'(q_item.row_index);
         if (q_item.first_k) begin
            acc_valid_in = '0;
         end
      end else if (busy_ff && adv) begin
         row_in  = row_ff + 1'b1;
         addr_in = addr_ff + ADDR_W'(MAX_DIM);
         if (row_last) begin
            busy_in = 1'b0;
         end
      end
      if (s2_valid_ff && adv) begin
         acc_valid_in[s2_row_ff] = 1'b1;
      end

      s1_valid_in = adv ? busy_ff : s1_valid_ff;
      s2_valid_in = adv ? s1_valid_ff : s2_valid_ff;

      rsp_valid_in = rsp_valid_ff;
      if (adv && s2_valid_ff && emit_ff) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         row_ff       <= '0;
         addr_ff      <= '0;
         acc_valid_ff <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         row_ff       <= row_in;
         addr_ff      <= addr_in;
         acc_valid_ff <= acc_valid_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Left matrix store: one write port for loads, one registered read port.
   always_ff @(posedge clock) begin
      if (load_write) begin
         store_mem[load_addr] <= q_item.value;
      end
      if (busy_ff && adv) begin
         a_rd_ff <= store_mem[addr_ff];
      end
   end

   // Row accumulators; an entry whose valid bit is clear reads as zero.
   always_ff @(posedge clock) begin
      if (s2_valid_ff && adv) begin
         acc_mem[s2_row_ff] <= acc_sum;
      end
      if (busy_ff && adv) begin
         acc_rd_ff <= acc_mem[row_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (stream_start) begin
         val_ff  <= q_item.value;
         col_ff  <= q_item.col_index;
         emit_ff <= q_item.last_k;
         eom_ff  <= q_item.last_col;
      end
      if (busy_ff && adv) begin
         acc_ok_ff     <= acc_valid_ff[row_ff];
         s1_row_ff     <= row_ff;
         s1_lastrow_ff <= row_last;
      end
      if (s1_valid_ff && adv) begin
         prod_ff       <= a_rd_ff * val_ff;
         base_ff       <= acc_ok_ff ? acc_rd_ff : '0;
         s2_row_ff     <= s1_row_ff;
         s2_lastrow_ff <= s1_lastrow_ff;
      end
      if (adv && s2_valid_ff && emit_ff) begin
         rsp_row_ff     <= mcme_pkg::ROW_W'(s2_row_ff);
         rsp_col_ff     <= col_ff;
         rsp_sum_ff     <= acc_sum;
         rsp_lastcol_ff <= s2_lastrow_ff;
         rsp_eom_ff     <= eom_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_row        = rsp_row_ff;
   assign rsp_out_col        = rsp_col_ff;
   assign rsp_sum_value      = rsp_sum_ff;
   assign rsp_last_of_column = rsp_lastcol_ff;
   assign rsp_last_of_matrix = rsp_eom_ff;

   assign status.pop     = q_pop;
   assign status.busy    = busy_ff;
   assign status.drained = drained;

endmodule

// ----- rtl/matrix_column_multiply_engine_core.sv -----
// ============================================================================
// Matrix column multiply engine core
// Load request: written into the store when the back end pops it. A streamed element
// closing a column sends its first response out through the row registers, the store
// read, the multiply stage and the accumulate into the response register. A streamed
// element holds the back end for one store read per active row and until its stages drain.
// Synchronous reset clears control, accumulator valid bits and registers to
// 16/16/16; the left matrix store holds no reset and needs no clearing pass.
// ============================================================================
module matrix_column_multiply_engine_core #(
   parameter int unsigned MAX_DIM = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mcme_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mcme_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_mode,
   input  logic [mcme_pkg::ROW_W-1:0]           req_row_index,
   input  logic [mcme_pkg::COL_W-1:0]           req_col_index,
   input  logic signed [mcme_pkg::VALUE_W-1:0]  req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [mcme_pkg::ROW_W-1:0]           rsp_out_row,
   output logic [mcme_pkg::COL_W-1:0]           rsp_out_col,
   output logic signed [mcme_pkg::SUM_W-1:0]    rsp_sum_value,
   output logic                                 rsp_last_of_column,
   output logic                                 rsp_last_of_matrix
);

   // The front end owns the three configuration registers and sorts each
   // request: loads outside the store and streamed elements whose inner
   // index is at or beyond the inner count are dropped at the door. Every
   // surviving request is tagged with its first-k, last-k and last-column
   // flags so the back end never looks at configuration except row count.
   localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);

   mcme_pkg::mcme_item_type          front_item;
   mcme_pkg::mcme_item_type          head_item;
   mcme_pkg::mcme_queue_status_type  queue_status;
   mcme_pkg::mcme_back_status_type   back_status;
   logic                             front_push;
   logic                             back_pop;
   logic [DIM_W-1:0]                 rows_eff;

   mcme_front #(
      .MAX_DIM (MAX_DIM),
      .DIM_W   (DIM_W)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_row_index (req_row_index),
      .req_col_index (req_col_index),
      .req_value     (req_value),
      .q_status      (queue_status),
      .q_push        (front_push),
      .q_item        (front_item),
      .rows_eff      (rows_eff)
   );

   // A four-entry queue lets the front keep taking loads and requests while
   // the back end is walking rows or waiting on a stalled response.
   mcme_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_item (front_item),
      .pop       (back_pop),
      .head_item (head_item),
      .status    (queue_status)
   );

   // The back end holds the left matrix store and the row accumulators. A
   // streamed element runs every active row through a store read, a 16 x 16
   // multiply and a 36-bit accumulate; when it carries the last inner index
   // each accumulate also lands in the response register. The response
   // register lets the pipe keep moving while a finished result waits, until the next result needs it.
   mcme_back #(
      .MAX_DIM (MAX_DIM),
      .DIM_W   (DIM_W)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_status           (queue_status),
      .q_item             (head_item),
      .q_pop              (back_pop),
      .rows_eff           (rows_eff),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_row        (rsp_out_row),
      .rsp_out_col        (rsp_out_col),
      .rsp_sum_value      (rsp_sum_value),
      .rsp_last_of_column (rsp_last_of_column),
      .rsp_last_of_matrix (rsp_last_of_matrix),
      .status             (back_status)
   );

   // The back end must never take a request out of an empty queue.
   a_pop_needs_entry : assert property (
      @(posedge clock) disable iff (reset)
      back_status.pop |-> queue_status.valid
   ) else $error("back end popped an empty request queue");

   // A streamed element may only start once the previous element's
   // accumulator writes have all retired, or a row would read a stale sum.
   a_stream_after_drain : assert property (
      @(posedge clock) disable iff (reset)
      (back_status.pop && (head_item.op == mcme_pkg::OP_STREAM)) |-> back_status.drained
   ) else $error("streamed element started before the accumulate pipe drained");

   // A load may not write the store while rows of an element are still read.
   a_load_when_free : assert property (
      @(posedge clock) disable iff (reset)
      (back_status.pop && (head_item.op == mcme_pkg::OP_LOAD)) |-> !back_status.busy
   ) else $error("load written while store reads were in progress");

endmodule

// ----- sim/matrix_column_multiply_engine_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Matrix column multiply engine core testbench
// Loads the left matrix, streams right-matrix columns under several register
// settings, and checks every row sum against an in-order software mirror of
// the engine, with random idling on both channels and one long result stall.
// ----------------------------------------------------------------------------
module matrix_column_multiply_engine_core_tb;

   localparam int unsigned DIM           = 16;
   localparam int unsigned IDLE_PCT      = 29;
   localparam int unsigned HOLD_CYCLES   = 200;
   // Covers the longest pipeline tail: a full-height column draining through the pipe.
   localparam int unsigned SETTLE_CYCLES = 32;
   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned QUIET_START   = 800;
   localparam int unsigned QUIET_END     = 1800;
   localparam int unsigned PHASES        = 5;
   // Index 3 is not a register; writes to it must leave everything unchanged.
   localparam logic [mcme_pkg::CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   // One request as it is offered on the input channel.
   typedef struct {
      mcme_pkg::mcme_op_type               op;
      logic [mcme_pkg::ROW_W-1:0]          row_index;
      logic [mcme_pkg::COL_W-1:0]          col_index;
      logic signed [mcme_pkg::VALUE_W-1:0] value;
   } request_type;

   // One row sum as it should appear on the result channel.
   typedef struct {
      logic [mcme_pkg::ROW_W-1:0]        out_row;
      logic [mcme_pkg::COL_W-1:0]        out_col;
      logic signed [mcme_pkg::SUM_W-1:0] sum_value;
      logic                              last_of_column;
      logic                              last_of_matrix;
   } column_sum_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [mcme_pkg::CSR_INDEX_W-1:0]     csr_index = '0;
   logic [mcme_pkg::CSR_DATA_W-1:0]      csr_wdata = '0;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic                                 req_mode = 1'b0;
   logic [mcme_pkg::ROW_W-1:0]           req_row_index = '0;
   logic [mcme_pkg::COL_W-1:0]           req_col_index = '0;
   logic signed [mcme_pkg::VALUE_W-1:0]  req_value = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic [mcme_pkg::ROW_W-1:0]           rsp_out_row;
   logic [mcme_pkg::COL_W-1:0]           rsp_out_col;
   logic signed [mcme_pkg::SUM_W-1:0]    rsp_sum_value;
   logic                                 rsp_last_of_column;
   logic                                 rsp_last_of_matrix;

   matrix_column_multiply_engine_core #(
      .MAX_DIM (DIM)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_row_index      (req_row_index),
      .req_col_index      (req_col_index),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_row        (rsp_out_row),
      .rsp_out_col        (rsp_out_col),
      .rsp_sum_value      (rsp_sum_value),
      .rsp_last_of_column (rsp_last_of_column),
      .rsp_last_of_matrix (rsp_last_of_matrix)
   );

   always #5 clock = ~clock;

   // Shared bookkeeping. The register copies are only changed while the
   // engine is idle, so the stimulus generator and the mirror can share them.
   request_type           pending_requests [$];
   column_sum_type        expected_sums [$];
   request_type           offered_request;
   logic [mcme_pkg::DIM_CFG_W-1:0]  row_count_reg   = mcme_pkg::ROW_COUNT_RESET;
   logic [mcme_pkg::DIM_CFG_W-1:0]  inner_count_reg = mcme_pkg::INNER_COUNT_RESET;
   logic [mcme_pkg::COLS_CFG_W-1:0] col_count_reg   = mcme_pkg::COL_COUNT_RESET;
   logic signed [mcme_pkg::VALUE_W-1:0] a_mirror [DIM][DIM];
   logic [mcme_pkg::SUM_W-1:0] row_acc [DIM];
   bit                    a_loaded [DIM][DIM];
   int unsigned           live_items = 0;
   int unsigned           cycle_count = 0;
   int unsigned           error_count = 0;
   logic                  hold_trigger = 1'b0;
   logic                  hold_used = 1'b0;
   int unsigned           hold_left = 0;
   logic                  quiet_window;

   // Both sides stop idling for one stretch of the run.
   assign quiet_window = (cycle_count >= QUIET_START) && (cycle_count < QUIET_END);

   initial begin
      foreach (row_acc[i]) row_acc[i] = '0;
      foreach (a_loaded[i, j]) begin
         a_loaded[i][j] = 1'b0;
         a_mirror[i][j] = '0;
      end
   end

   // Registers saturate into 1..hi when they are read.
   function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // Mirror of the engine for one accepted request. A load writes the left
   // matrix copy when it lands inside the store. A streamed element with an
   // inner index in range clears the row sums on k = 0, adds A[i][k] * B[k][j]
   // into every active row, and on the last inner index queues one sum per
   // active row in row order.
   function automatic void multiply_into_rows(input request_type r);
      int unsigned        rows;
      int unsigned        inner;
      int unsigned        cols;
      logic signed [31:0] product;
      column_sum_type     sum;
      rows  = clamp_dim(row_count_reg, DIM);
      inner = clamp_dim(inner_count_reg, DIM);
      cols  = clamp_dim(col_count_reg, mcme_pkg::MAX_COLS);
      if (r.op == mcme_pkg::OP_LOAD) begin
         if (r.col_index < DIM) a_mirror[r.row_index][r.col_index] = r.value;
         return;
      end
      if (r.row_index >= inner) return;
      if (r.row_index == 0) foreach (row_acc[i]) row_acc[i] = '0;
      for (int unsigned i = 0; i < rows; i++) begin
         product = a_mirror[i][r.row_index] * r.value;
         row_acc[i] = row_acc[i] + {{(mcme_pkg::SUM_W-32){product[31]}}, product};
      end
      if (r.row_index == inner - 1) begin
         for (int unsigned i = 0; i < rows; i++) begin
            sum.out_row        = mcme_pkg::ROW_W'(i);
            sum.out_col        = r.col_index;
            sum.sum_value      = row_acc[i];
            sum.last_of_column = (i == rows - 1);
            sum.last_of_matrix = (r.col_index == cols - 1);
            expected_sums.push_back(sum);
         end
      end
   endfunction

   // Input driver. A request that is stalled stays on the port unchanged;
   // otherwise the next pending request is offered unless this cycle idles.
   always @(posedge clock) begin : request_driver
      request_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) multiply_into_rows(offered_request);
         if (!req_valid || !req_stall) begin
            if (pending_requests.size() != 0 &&
                (quiet_window || $urandom_range(99) >= IDLE_PCT)) begin
               next_req        = pending_requests.pop_front();
               offered_request = next_req;
               req_valid     <= 1'b1;
               req_mode      <= next_req.op;
               req_row_index <= next_req.row_index;
               req_col_index <= next_req.col_index;
               req_value     <= next_req.value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result receiver. The long hold runs once, when the stimulus asks for
   // it, and keeps the output stalled while requests keep arriving so that
   // the engine backs up all the way to its input.
   always @(posedge clock) begin : result_receiver
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_trigger && !hold_used) begin
         hold_used <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !quiet_window && ($urandom_range(99) < IDLE_PCT);
      end
   end

   // Result monitor: every accepted sum is matched against the oldest one
   // the mirror produced.
   always @(posedge clock) begin : result_monitor
      column_sum_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_sums.size() == 0) begin
            $error("unexpected result: row %0d col %0d sum %0d",
                   rsp_out_row, rsp_out_col, rsp_sum_value);
            error_count++;
         end else begin
            want = expected_sums.pop_front();
            if (rsp_out_row !== want.out_row) begin
               $error("out_row: expected %0d, got %0d", want.out_row, rsp_out_row);
               error_count++;
            end
            if (rsp_out_col !== want.out_col) begin
               $error("out_col: expected %0d, got %0d", want.out_col, rsp_out_col);
               error_count++;
            end
            if (rsp_sum_value !== want.sum_value) begin
               $error("sum_value: expected %0d, got %0d", want.sum_value, rsp_sum_value);
               error_count++;
            end
            if (rsp_last_of_column !== want.last_of_column) begin
               $error("last_of_column: expected %0d, got %0d",
                      want.last_of_column, rsp_last_of_column);
               error_count++;
            end
            if (rsp_last_of_matrix !== want.last_of_matrix) begin
               $error("last_of_matrix: expected %0d, got %0d",
                      want.last_of_matrix, rsp_last_of_matrix);
               error_count++;
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin : run_watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL matrix_column_multiply_engine_core");
         $finish;
      end
   end

   // Stimulus helpers. Loads record which store entries hold data so that a
   // streamed element never reads an entry that was never written.
   task automatic queue_load(input int unsigned row, input int unsigned col,
                             input logic [mcme_pkg::VALUE_W-1:0] value);
      request_type r;
      r.op        = mcme_pkg::OP_LOAD;
      r.row_index = mcme_pkg::ROW_W'(row);
      r.col_index = mcme_pkg::COL_W'(col);
      r.value     = value;
      if (col < DIM) begin
         a_loaded[row][col] = 1'b1;
         live_items++;
      end
      pending_requests.push_back(r);
   endtask

   task automatic queue_stream(input int unsigned k, input int unsigned tag,
                               input logic [mcme_pkg::VALUE_W-1:0] value);
      request_type r;
      r.op        = mcme_pkg::OP_STREAM;
      r.row_index = mcme_pkg::ROW_W'(k);
      r.col_index = mcme_pkg::COL_W'(tag);
      r.value     = value;
      if (k < clamp_dim(inner_count_reg, DIM)) live_items++;
      pending_requests.push_back(r);
   endtask

   // Mostly uniform values, with the Q8.8 extremes mixed in.
   function automatic logic [mcme_pkg::VALUE_W-1:0] random_value();
      case ($urandom_range(19))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'hFFFF;
         default: return mcme_pkg::VALUE_W'($urandom);
      endcase
   endfunction

   // One column of B with random content. Most columns are complete runs of
   // k = 0 .. inner-1; some skip the clearing k = 0, repeat an element or are
   // abandoned part way, and noise (loads outside the store, out-of-range
   // inner indexes, reloads of A) is sprinkled in between.
   task automatic queue_column(input int unsigned tag);
      int unsigned rows;
      int unsigned inner;
      int unsigned first_k;
      rows    = clamp_dim(row_count_reg, DIM);
      inner   = clamp_dim(inner_count_reg, DIM);
      first_k = (inner > 1 && $urandom_range(99) < 10) ? 1 : 0;
      for (int unsigned k = first_k; k < inner; k++) begin
         if ($urandom_range(99) < 8) begin
            case ($urandom_range(2))
               0: queue_load($urandom_range(DIM - 1), $urandom_range(1023, DIM),
                             random_value());
               1: if (inner < DIM)
                     queue_stream($urandom_range(DIM - 1, inner), tag, random_value());
               default: queue_load($urandom_range(DIM - 1), $urandom_range(DIM - 1),
                                   random_value());
            endcase
         end
         if (k > first_k && $urandom_range(99) < 4) break;
         for (int unsigned i = 0; i < rows; i++)
            if (!a_loaded[i][k]) queue_load(i, k, random_value());
         queue_stream(k, tag, random_value());
         if ($urandom_range(99) < 4) queue_stream(k, tag, random_value());
      end
   endtask

   // Register write; starts and ends right after a rising edge.
   task automatic write_register(input logic [mcme_pkg::CSR_INDEX_W-1:0] index,
                                 input logic [mcme_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         mcme_pkg::CSR_ROW_COUNT:   row_count_reg   = data[mcme_pkg::DIM_CFG_W-1:0];
         mcme_pkg::CSR_INNER_COUNT: inner_count_reg = data[mcme_pkg::DIM_CFG_W-1:0];
         mcme_pkg::CSR_COL_COUNT:   col_count_reg   = data[mcme_pkg::COLS_CFG_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Sender pause: everything offered, every sum back, then the pipeline
   // tail for elements that produce no result.
   task automatic wait_for_idle();
      do @(posedge clock);
      while (pending_requests.size() != 0 || req_valid || expected_sums.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Main sequence: reset, a directed 2x2 case, then random phases that
   // sweep the registers through their extremes, including values that
   // saturate (zero, 31 and 2047) and a write to the unused index.
   initial begin : stimulus
      int unsigned phase_rows  [PHASES];
      int unsigned phase_inner [PHASES];
      int unsigned phase_cols  [PHASES];
      int unsigned phase_goal  [PHASES];
      int unsigned next_tag;
      int unsigned tag;
      int unsigned cols;
      phase_rows  = '{0, 5, 31, 16, 1};
      phase_inner = '{31, 3, 0, 2, 16};
      phase_cols  = '{0, 4, 2047, 1024, 1};
      phase_goal  = '{35, 60, 35, 35, 35};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: 2 rows, inner 2, 2 columns, with extreme values.
      write_register(mcme_pkg::CSR_ROW_COUNT, 11'd2);
      write_register(mcme_pkg::CSR_INNER_COUNT, 11'd2);
      write_register(mcme_pkg::CSR_COL_COUNT, 11'd2);
      queue_load(0, 0, 16'h7FFF);
      queue_load(0, 1, 16'h8000);
      queue_load(1, 0, 16'h8000);
      queue_load(1, 1, 16'hFFFF);
      // Loads outside the store are dropped.
      queue_load(15, 1023, 16'h1234);
      queue_load(3, 16, 16'h5A5A);
      queue_stream(0, 0, 16'h8000);
      queue_stream(1, 0, 16'h8000);
      // No k = 0 here, so the sums keep adding to the previous column;
      // tag 1 is the final column.
      queue_stream(1, 1, 16'h7FFF);
      // Inner indexes at or beyond the inner count are ignored.
      queue_stream(15, 5, 16'h7FFF);
      queue_stream(2, 0, 16'h0001);
      queue_stream(0, 1023, 16'h0000);
      queue_stream(1, 1023, 16'hFFFF);
      wait_for_idle();

      for (int unsigned p = 0; p < PHASES; p++) begin
         write_register(mcme_pkg::CSR_ROW_COUNT, mcme_pkg::CSR_DATA_W'(phase_rows[p]));
         write_register(mcme_pkg::CSR_INNER_COUNT, mcme_pkg::CSR_DATA_W'(phase_inner[p]));
         write_register(mcme_pkg::CSR_COL_COUNT, mcme_pkg::CSR_DATA_W'(phase_cols[p]));
         if (p == 1) write_register(CSR_SPARE, mcme_pkg::CSR_DATA_W'($urandom_range(2047)));
         cols       = clamp_dim(col_count_reg, mcme_pkg::MAX_COLS);
         next_tag   = 0;
         live_items = 0;
         while (live_items < phase_goal[p]) begin
            // Mostly walk the columns in order so the final column is hit.
            tag = ($urandom_range(99) < 25) ? $urandom_range(1023) : next_tag % cols;
            next_tag++;
            queue_column(tag);
         end
         if (p == 1) hold_trigger <= 1'b1;
         wait_for_idle();
      end

      if (error_count == 0) begin
         $display("PASS matrix_column_multiply_engine_core");
      end else begin
         $display("FAIL matrix_column_multiply_engine_core");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/mcme_pkg.sv
rtl/mcme_front.sv
rtl/mcme_queue.sv
rtl/mcme_back.sv
rtl/matrix_column_multiply_engine_core.sv
sim/matrix_column_multiply_engine_core_tb.sv
